FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the graph reachability checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define FRG_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frg assertion failed");

// Implication into the next cycle, disabled during reset.
`define FRG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frg assertion failed");

// Implication into the next cycle, also checked during reset.
`define FRG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("frg assertion failed");

`endif

FILE: hw/rtl/frg_pkg.sv
// ----------------------------------------------------------------------------
// Filtered graph reachability package
// Sizes, command and kind codes, request and response types.
// ----------------------------------------------------------------------------
package frg_pkg;

  localparam int MAX_NODES = 4096;
  localparam int MAX_EDGES = 16384;
  localparam int NODE_W    = 12;
  localparam int EADDR_W   = 14;
  localparam int ECNT_W    = 15;
  localparam int NCNT_W    = 13;
  localparam int EDGE_W    = 27;
  localparam int VWORDS    = 64;
  localparam int VADDR_W   = 6;

  localparam logic [1:0] CMD_EDGE = 2'd0;
  localparam logic [1:0] CMD_SEED = 2'd1;
  localparam logic [1:0] CMD_RUN  = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [2:0] KIND_COMB  = 3'd0;
  localparam logic [2:0] KIND_SEQ   = 3'd1;
  localparam logic [2:0] KIND_CLOCK = 3'd2;
  localparam logic [2:0] KIND_RESET = 3'd3;
  localparam logic [2:0] KIND_HIER  = 3'd4;

  localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] REG_SEQ_BLOCKED = 2'd1;

  typedef struct packed {
    logic [NCNT_W-1:0] node_count;
    logic              seq_blocked;
  } cfg_t;

  typedef struct packed {
    logic [NODE_W-1:0] seed_node;
    logic [2:0]        edge_kind;
    logic [NODE_W-1:0] edge_target;
    logic [NODE_W-1:0] edge_source;
    logic [1:0]        cmd;
  } req_t;

  typedef struct packed {
    logic        last;
    logic        overflow;
    logic [63:0] members;
    logic [5:0]  word_index;
  } rsp_t;

  function automatic logic kind_allowed(input logic [2:0] k, input logic seq_blocked);
    logic ok;
    ok = 1'b0;
    case (k) inside
      KIND_COMB, KIND_CLOCK, KIND_RESET, KIND_HIER: ok = 1'b1;
      KIND_SEQ: ok = !seq_blocked;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: hw/rtl/frg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/frg_engine.sv
// ----------------------------------------------------------------------------
// Graph walk engine
// Stores edges and seeds, builds compressed adjacency rows, walks depth
// first over a memory stack and emits the visited set word by word.
// ----------------------------------------------------------------------------
module frg_engine (
  input  logic          clk,
  input  logic          rst,
  input  frg_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  frg_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output frg_pkg::rsp_t out_rsp
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_SEED_V = 5'd2;
  localparam logic [4:0] S_CLF    = 5'd3;
  localparam logic [4:0] S_CNT_RD = 5'd4;
  localparam logic [4:0] S_CNT_EV = 5'd5;
  localparam logic [4:0] S_CNT_WR = 5'd6;
  localparam logic [4:0] S_PFX_RD = 5'd7;
  localparam logic [4:0] S_PFX_WR = 5'd8;
  localparam logic [4:0] S_PLC_RD = 5'd9;
  localparam logic [4:0] S_PLC_EV = 5'd10;
  localparam logic [4:0] S_PLC_WR = 5'd11;
  localparam logic [4:0] S_POP    = 5'd12;
  localparam logic [4:0] S_POP_EV = 5'd13;
  localparam logic [4:0] S_ROW    = 5'd14;
  localparam logic [4:0] S_EDG    = 5'd15;
  localparam logic [4:0] S_EDG_D  = 5'd16;
  localparam logic [4:0] S_EDG_V  = 5'd17;
  localparam logic [4:0] S_EM_RD  = 5'd18;
  localparam logic [4:0] S_EM_OUT = 5'd19;
  localparam logic [4:0] S_EM_WT  = 5'd20;

  logic [4:0]                     state;
  logic [frg_pkg::NCNT_W-1:0]     idx;
  logic [frg_pkg::ECNT_W-1:0]     eptr;
  logic [frg_pkg::ECNT_W-1:0]     eend;
  logic [frg_pkg::ECNT_W-1:0]     ecnt;
  logic [frg_pkg::ECNT_W-1:0]     run;
  logic [frg_pkg::NCNT_W-1:0]     sp;
  logic                           ovf;
  logic [frg_pkg::EDGE_W-1:0]     ehold;
  logic [frg_pkg::NODE_W-1:0]     node;
  logic [frg_pkg::VADDR_W-1:0]    clr;
  logic [6:0]                     wcnt;

  logic                           edge_we;
  logic [frg_pkg::EDGE_W-1:0]     edge_rd;
  logic                           fill_we;
  logic [frg_pkg::NODE_W-1:0]     fill_wa;
  logic [frg_pkg::ECNT_W-1:0]     fill_wd;
  logic [frg_pkg::NODE_W-1:0]     fill_ra;
  logic [frg_pkg::ECNT_W-1:0]     fill_rd;
  logic [frg_pkg::ECNT_W-1:0]     start_rd;
  logic                           adj_we;
  logic [frg_pkg::NODE_W-1:0]     adj_rd;
  logic                           vis_we;
  logic [frg_pkg::VADDR_W-1:0]    vis_wa;
  logic [63:0]                    vis_wd;
  logic [frg_pkg::VADDR_W-1:0]    vis_ra;
  logic [63:0]                    vis_rd;
  logic                           stk_we;
  logic [frg_pkg::NODE_W-1:0]     stk_ra;
  logic [frg_pkg::NODE_W-1:0]     stk_rd;

  logic                           acc;
  logic [frg_pkg::NODE_W-1:0]     e_src;
  logic [frg_pkg::NODE_W-1:0]     e_dst;
  logic                           e_use;
  logic [frg_pkg::NODE_W-1:0]     h_src;
  logic                           vbit;
  logic [6:0]                     nfull;
  logic [6:0]                     words;
  logic [63:0]                    mask;
  logic [frg_pkg::NCNT_W-1:0]     sp_dec;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign e_src    = edge_rd[26:15];
  assign e_dst    = edge_rd[14:3];
  assign e_use    = ({1'b0, e_src} < cfg.node_count) && ({1'b0, e_dst} < cfg.node_count) &&
                    frg_pkg::kind_allowed(edge_rd[2:0], cfg.seq_blocked);
  assign h_src    = ehold[26:15];
  assign vbit     = vis_rd[node[5:0]];
  assign nfull    = cfg.node_count[12:6];
  assign words    = nfull + {6'd0, (cfg.node_count[5:0] != 6'd0)};
  assign sp_dec   = sp - 13'd1;
  assign edge_we  = acc && (in_req.cmd == frg_pkg::CMD_EDGE) &&
                    (ecnt < frg_pkg::ECNT_W'(frg_pkg::MAX_EDGES));
  assign adj_we   = (state == S_PLC_WR);
  assign stk_we   = ((state == S_SEED_V) || (state == S_EDG_V)) && !vbit;
  assign stk_ra   = sp_dec[11:0];

  always_comb begin
    if (wcnt < nfull) begin
      mask = '1;
    end else if (wcnt == nfull) begin
      mask = (64'd1 << cfg.node_count[5:0]) - 64'd1;
    end else begin
      mask = '0;
    end
  end

  always_comb begin
    fill_we = 1'b0;
    fill_wa = idx[11:0];
    fill_wd = '0;
    fill_ra = idx[11:0];
    unique case (state)
      S_CLF: fill_we = (idx != cfg.node_count);
      S_CNT_EV, S_PLC_EV: fill_ra = e_src;
      S_CNT_WR, S_PLC_WR: begin
        fill_we = 1'b1;
        fill_wa = h_src;
        fill_wd = fill_rd + 15'd1;
      end
      S_PFX_WR: begin
        fill_we = 1'b1;
        fill_wd = run;
      end
      S_POP_EV: fill_ra = stk_rd;
      default: ;
    endcase
  end

  always_comb begin
    vis_we = 1'b0;
    vis_wa = node[11:6];
    vis_wd = vis_rd | (64'd1 << node[5:0]);
    vis_ra = wcnt[5:0];
    unique case (state)
      S_CLR: begin
        vis_we = 1'b1;
        vis_wa = clr;
        vis_wd = '0;
      end
      S_IDLE: vis_ra = in_req.seed_node[11:6];
      S_SEED_V, S_EDG_V: vis_we = !vbit;
      S_EDG_D: vis_ra = adj_rd[11:6];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      ecnt      <= '0;
      sp        <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr <= clr + 6'd1;
          if (clr == 6'd63) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            node <= in_req.seed_node;
            if (in_req.cmd == frg_pkg::CMD_EDGE) begin
              if (edge_we) begin
                ecnt <= ecnt + 15'd1;
              end else begin
                ovf <= 1'b1;
              end
            end else if (in_req.cmd == frg_pkg::CMD_SEED) begin
              state <= S_SEED_V;
            end else if (in_req.cmd == frg_pkg::CMD_RUN) begin
              idx   <= '0;
              state <= S_CLF;
            end
          end
        end
        S_SEED_V: begin
          if (!vbit) begin
            sp <= sp + 13'd1;
          end
          state <= S_IDLE;
        end
        S_CLF: begin
          if (idx == cfg.node_count) begin
            eptr  <= '0;
            state <= S_CNT_RD;
          end else begin
            idx <= idx + 13'd1;
          end
        end
        S_CNT_RD, S_PLC_RD: begin
          if (eptr == ecnt) begin
            idx   <= '0;
            run   <= '0;
            eptr  <= '0;
            state <= (state == S_CNT_RD) ? S_PFX_RD : S_POP;
          end else begin
            state <= (state == S_CNT_RD) ? S_CNT_EV : S_PLC_EV;
          end
        end
        S_CNT_EV, S_PLC_EV: begin
          ehold <= edge_rd;
          if (e_use) begin
            state <= (state == S_CNT_EV) ? S_CNT_WR : S_PLC_WR;
          end else begin
            eptr  <= eptr + 15'd1;
            state <= (state == S_CNT_EV) ? S_CNT_RD : S_PLC_RD;
          end
        end
        S_CNT_WR, S_PLC_WR: begin
          eptr  <= eptr + 15'd1;
          state <= (state == S_CNT_WR) ? S_CNT_RD : S_PLC_RD;
        end
        S_PFX_RD: begin
          state <= (idx == cfg.node_count) ? S_PLC_RD : S_PFX_WR;
        end
        S_PFX_WR: begin
          run   <= run + fill_rd;
          idx   <= idx + 13'd1;
          state <= S_PFX_RD;
        end
        S_POP: begin
          if (sp == '0) begin
            wcnt  <= '0;
            state <= S_EM_RD;
          end else begin
            sp    <= sp_dec;
            state <= S_POP_EV;
          end
        end
        S_POP_EV: begin
          state <= ({1'b0, stk_rd} < cfg.node_count) ? S_ROW : S_POP;
        end
        S_ROW: begin
          eptr  <= start_rd;
          eend  <= fill_rd;
          state <= S_EDG;
        end
        S_EDG: begin
          state <= (eptr < eend) ? S_EDG_D : S_POP;
        end
        S_EDG_D: begin
          node  <= adj_rd;
          state <= S_EDG_V;
        end
        S_EDG_V: begin
          if (!vbit) begin
            sp <= sp + 13'd1;
          end
          eptr  <= eptr + 15'd1;
          state <= S_EDG;
        end
        S_EM_RD: begin
          state <= S_EM_OUT;
        end
        S_EM_OUT: begin
          out_rsp.word_index <= wcnt[5:0];
          out_rsp.members    <= vis_rd & mask;
          out_rsp.overflow   <= ovf;
          out_rsp.last       <= ((wcnt + 7'd1) >= words);
          out_valid          <= 1'b1;
          state              <= S_EM_WT;
        end
        S_EM_WT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_rsp.last) begin
              ecnt  <= '0;
              sp    <= '0;
              ovf   <= 1'b0;
              clr   <= '0;
              state <= S_CLR;
            end else begin
              wcnt  <= wcnt + 7'd1;
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  frg_ram #(.WIDTH(frg_pkg::EDGE_W), .DEPTH(frg_pkg::MAX_EDGES)) u_edge (
    .clk  (clk),
    .we   (edge_we),
    .waddr(ecnt[13:0]),
    .wdata({in_req.edge_source, in_req.edge_target, in_req.edge_kind}),
    .raddr(eptr[13:0]),
    .rdata(edge_rd)
  );

  frg_ram #(.WIDTH(frg_pkg::ECNT_W), .DEPTH(frg_pkg::MAX_NODES)) u_fill (
    .clk  (clk),
    .we   (fill_we),
    .waddr(fill_wa),
    .wdata(fill_wd),
    .raddr(fill_ra),
    .rdata(fill_rd)
  );

  frg_ram #(.WIDTH(frg_pkg::ECNT_W), .DEPTH(frg_pkg::MAX_NODES)) u_start (
    .clk  (clk),
    .we   (state == S_PFX_WR),
    .waddr(idx[11:0]),
    .wdata(run),
    .raddr(stk_rd),
    .rdata(start_rd)
  );

  frg_ram #(.WIDTH(frg_pkg::NODE_W), .DEPTH(frg_pkg::MAX_EDGES)) u_adj (
    .clk  (clk),
    .we   (adj_we),
    .waddr(fill_rd[13:0]),
    .wdata(ehold[14:3]),
    .raddr(eptr[13:0]),
    .rdata(adj_rd)
  );

  frg_ram #(.WIDTH(64), .DEPTH(frg_pkg::VWORDS)) u_vis (
    .clk  (clk),
    .we   (vis_we),
    .waddr(vis_wa),
    .wdata(vis_wd),
    .raddr(vis_ra),
    .rdata(vis_rd)
  );

  frg_ram #(.WIDTH(frg_pkg::NODE_W), .DEPTH(frg_pkg::MAX_NODES)) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(sp[11:0]),
    .wdata(node),
    .raddr(stk_ra),
    .rdata(stk_rd)
  );

endmodule

FILE: hw/rtl/filtered_graph_reachability.sv
// A run first builds the adjacency rows from the stored edges, then expands the nodes
// on the stack and follows their edges, and last emits the visited set word by word,
// waiting on output stalls. Requests are taken one at a time.
// Reset (synchronous) and the end of every run start a clearing pass of the visited
// memory, during which no request is taken.
// ----------------------------------------------------------------------------
// Filtered graph reachability
// Top level with configuration registers and stream port packing.
// ----------------------------------------------------------------------------
module filtered_graph_reachability (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd, edge_source, edge_target, edge_kind, seed_node, zero fill
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // word_index, members, zero fill
  output logic [71:0] m_axis_tdata,
  // overflow
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  logic [12:0]   node_count;
  logic          seq_blocked;
  frg_pkg::cfg_t cfg;
  frg_pkg::req_t req;
  frg_pkg::rsp_t rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= '0;
      seq_blocked <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        frg_pkg::REG_NODE_COUNT:  node_count  <= cfg_data;
        frg_pkg::REG_SEQ_BLOCKED: seq_blocked <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.node_count  = (node_count > 13'(frg_pkg::MAX_NODES)) ?
                           13'(frg_pkg::MAX_NODES) : node_count;
  assign cfg.seq_blocked = seq_blocked;
  assign req             = s_axis_tdata[40:0];

  frg_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_req   (req),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_rsp  (rsp)
  );

  assign m_axis_tdata = {2'b00, rsp.members, rsp.word_index};
  assign m_axis_tuser = rsp.overflow;
  assign m_axis_tlast = rsp.last;

endmodule

FILE: hw/rtl/frg_checker.sv
// ----------------------------------------------------------------------------
// Graph reachability port checker
// Checks the request and result ordering seen at the top level ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic last_acc;
  logic mid_word;

  assign last_acc = m_axis_tvalid && m_axis_tready && m_axis_tlast;
  assign mid_word = m_axis_tvalid && !m_axis_tlast;

  `FRG_ASSERT_IMPLY(a_no_req_while_result, clk, rst, m_axis_tvalid, !s_axis_tready)
  `FRG_ASSERT_NEXT(a_clear_after_last, clk, rst, last_acc, !s_axis_tready)
  `FRG_ASSERT_IMPLY(a_last_word_bound, clk, rst, mid_word, m_axis_tdata[5:0] != 6'd63)
  `FRG_ASSERT_NEXT(a_valid_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `FRG_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !s_axis_tready && !m_axis_tvalid)

endmodule

bind filtered_graph_reachability frg_checker u_frg_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

FILE: bench/filtered_graph_reachability_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Filtered graph reachability testbench
// Loads small random graphs and seeds, runs the walk under several idle and
// stall mixes, and checks every membership word against a scoreboard that
// computes the reached set on its own.
// ----------------------------------------------------------------------------
module filtered_graph_reachability_test;

  class reach_scoreboard;
    int unsigned   node_count;
    bit            seq_blocked;
    bit [26:0]     edges[$];
    bit            ovf;
    bit            seeded[frg_pkg::MAX_NODES];
    int            seeds[$];
    frg_pkg::rsp_t expected[$];

    function void set_reg(logic [1:0] idx, logic [12:0] v);
      if (idx == frg_pkg::REG_NODE_COUNT) node_count = v;
      else if (idx == frg_pkg::REG_SEQ_BLOCKED) seq_blocked = v[0];
    endfunction

    function bit followed(bit [2:0] k);
      case (k) inside
        frg_pkg::KIND_COMB, frg_pkg::KIND_CLOCK, frg_pkg::KIND_RESET,
        frg_pkg::KIND_HIER: return 1'b1;
        frg_pkg::KIND_SEQ: return !seq_blocked;
        default: return 1'b0;
      endcase
    endfunction

    function void note_request(frg_pkg::req_t r);
      int            n, words, cur, s, d;
      int            adj[frg_pkg::MAX_NODES][$];
      bit            vis[frg_pkg::MAX_NODES];
      int            work[$];
      bit [26:0]     ew;
      frg_pkg::rsp_t w;
      if (r.cmd == frg_pkg::CMD_EDGE) begin
        ew = {r.edge_source, r.edge_target, r.edge_kind};
        if (edges.size() < frg_pkg::MAX_EDGES) edges.insert(edges.size(), ew);
        else ovf = 1;
      end else if (r.cmd == frg_pkg::CMD_SEED) begin
        if (!seeded[r.seed_node]) begin
          seeded[r.seed_node] = 1;
          seeds.insert(seeds.size(), r.seed_node);
        end
      end else if (r.cmd == frg_pkg::CMD_RUN) begin
        n = node_count < frg_pkg::MAX_NODES ? node_count : frg_pkg::MAX_NODES;
        foreach (edges[i]) begin
          s = edges[i][26:15];
          d = edges[i][14:3];
          if (s < n && d < n && followed(edges[i][2:0])) adj[s].insert(adj[s].size(), d);
        end
        foreach (seeds[i]) begin
          vis[seeds[i]] = 1;
          if (seeds[i] < n) work.insert(work.size(), seeds[i]);
        end
        while (work.size() > 0) begin
          cur = work.pop_front();
          foreach (adj[cur][j]) if (!vis[adj[cur][j]]) begin
            vis[adj[cur][j]] = 1;
            work.insert(work.size(), adj[cur][j]);
          end
        end
        words = (n + 63) / 64;
        if (words == 0) words = 1;
        for (int wi = 0; wi < words; wi++) begin
          w.word_index = 6'(wi);
          w.members = '0;
          for (int b = 0; b < 64; b++) if (wi * 64 + b < n && vis[wi * 64 + b]) w.members[b] = 1;
          w.overflow = ovf;
          w.last = (wi + 1 == words);
          expected.insert(expected.size(), w);
        end
        edges.delete();
        seeds.delete();
        seeded = '{default: 0};
        ovf = 0;
      end
    endfunction

    function string check_result(frg_pkg::rsp_t r);
      frg_pkg::rsp_t e;
      if (expected.size() == 0) return $sformatf("unexpected word %0d", r.word_index);
      e = expected.pop_front();
      if (r.word_index != e.word_index)
        return $sformatf("word_index %0d, expected %0d", r.word_index, e.word_index);
      if (r.members !== e.members)
        return $sformatf("word %0d members %h, expected %h", e.word_index, r.members, e.members);
      if (r.overflow !== e.overflow)
        return $sformatf("word %0d overflow %b, expected %b", e.word_index, r.overflow, e.overflow);
      if (r.last !== e.last)
        return $sformatf("word %0d last %b, expected %b", e.word_index, r.last, e.last);
      return "";
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  localparam int HOLD_OFF = 3000;
  localparam int WATCHDOG = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  reach_scoreboard sb = new;
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet = 0;

  filtered_graph_reachability uut (.*);

  always #1 clk = ~clk;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    string         msg;
    frg_pkg::rsp_t r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      r.word_index = m_axis_tdata[5:0];
      r.members = m_axis_tdata[69:6];
      r.overflow = m_axis_tuser;
      r.last = m_axis_tlast;
      msg = sb.check_result(r);
      if (msg != "") report(msg);
    end
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_OFF;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("** filtered_graph_reachability: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(frg_pkg::req_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'b0, r.seed_node, r.edge_kind, r.edge_target, r.edge_source, r.cmd};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(r);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_input();
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int v);
    wait_drained();
    repeat (100) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= 13'(v);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, 13'(v));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic frg_pkg::req_t make_req(logic [1:0] c, int s, int d, int k, int sd);
    frg_pkg::req_t r;
    r.cmd = c;
    r.edge_source = 12'(s);
    r.edge_target = 12'(d);
    r.edge_kind = 3'(k);
    r.seed_node = 12'(sd);
    return r;
  endfunction

  function automatic int pick_node(int hi);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, frg_pkg::MAX_NODES - 1);
    return $urandom_range(0, hi);
  endfunction

  task automatic random_graph(int n_items);
    int hi;
    hi = sb.node_count + 1 > frg_pkg::MAX_NODES - 1 ? frg_pkg::MAX_NODES - 1 :
         sb.node_count + 1;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(0, 19))
        0: send(make_req(frg_pkg::CMD_NOP, $urandom, $urandom, $urandom, $urandom));
        1, 2, 3, 4: send(make_req(frg_pkg::CMD_SEED, $urandom, $urandom, $urandom,
                                  pick_node(hi)));
        default: send(make_req(frg_pkg::CMD_EDGE, pick_node(hi), pick_node(hi),
                               $urandom_range(0, 7), $urandom));
      endcase
    end
    send(make_req(frg_pkg::CMD_RUN, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic random_config();
    int pick;
    pick = $urandom_range(0, 9);
    write_reg(frg_pkg::REG_NODE_COUNT, pick == 0 ? frg_pkg::MAX_NODES :
                                       pick < 3 ? $urandom_range(0, 2) * 64 + 1 :
                                       $urandom_range(2, 150));
    write_reg(frg_pkg::REG_SEQ_BLOCKED, $urandom_range(0, 1));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Empty node range, then the widest range with each edge kind and seed corner.
    send(make_req(frg_pkg::CMD_RUN, 0, 0, 0, 0));
    write_reg(frg_pkg::REG_NODE_COUNT, frg_pkg::MAX_NODES);
    write_reg(frg_pkg::REG_SEQ_BLOCKED, 0);
    for (int k = 0; k < 8; k++) send(make_req(frg_pkg::CMD_EDGE, k * 500, k * 500 + 1, k, 0));
    send(make_req(frg_pkg::CMD_EDGE, 0, 4095, frg_pkg::KIND_SEQ, 0));
    send(make_req(frg_pkg::CMD_EDGE, 4095, 3500, frg_pkg::KIND_COMB, 0));
    send(make_req(frg_pkg::CMD_EDGE, 4095, 4095, frg_pkg::KIND_HIER, 0));
    for (int k = 0; k < 8; k++) send(make_req(frg_pkg::CMD_SEED, 0, 0, 0, k * 500));
    send(make_req(frg_pkg::CMD_SEED, 4095, 4095, 7, 0));
    send(make_req(frg_pkg::CMD_SEED, 0, 0, 0, 0));
    send(make_req(frg_pkg::CMD_NOP, 4095, 4095, 7, 4095));
    send(make_req(frg_pkg::CMD_RUN, 4095, 4095, 7, 4095));
    write_reg(frg_pkg::REG_SEQ_BLOCKED, 1);
    write_reg(frg_pkg::REG_NODE_COUNT, 100);
    send(make_req(frg_pkg::CMD_EDGE, 1, 2, frg_pkg::KIND_SEQ, 0));
    send(make_req(frg_pkg::CMD_EDGE, 1, 3, frg_pkg::KIND_CLOCK, 0));
    send(make_req(frg_pkg::CMD_EDGE, 3, 150, frg_pkg::KIND_COMB, 0));
    send(make_req(frg_pkg::CMD_SEED, 0, 0, 0, 1));
    send(make_req(frg_pkg::CMD_SEED, 0, 0, 0, 120));
    send(make_req(frg_pkg::CMD_RUN, 0, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = ph == 1 ? 81 : ph == 3 ? 14 : 0;
      recv_stall = ph == 2 ? 81 : ph == 3 ? 14 : 0;
      for (int g = 0; g < 3; g++) begin
        random_config();
        random_graph($urandom_range(6, 18));
      end
      if (ph == 2) begin
        write_reg(frg_pkg::REG_NODE_COUNT, 130);
        hold_req = 1;
        for (int g = 0; g < 4; g++) random_graph(4);
        wait_drained();
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("** filtered_graph_reachability: PASSED **");
    end else begin
      $display("** filtered_graph_reachability: FAILED **");
    end
    $finish;
  end
endmodule
